FILE: rtl/s2dec_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
`default_nettype none

package s2dec_pkg;

  // Input word width
  localparam int VALUE_BITS    = 32;
  // Decimal digits needed for the largest magnitude, 2**VALUE_BITS - 1 at most
  localparam int MAG_DIGITS    = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int DIG_IDX_W     = $clog2(MAG_DIGITS);
  // Double-dabble: magnitude bits consumed per clock
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHIFT_BITS    = CONV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;
  // Decimal mode pads to at least this many digits
  localparam int MIN_DIGITS    = 3;
  // Queue between front and back
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef logic [MAG_DIGITS-1:0][3:0] s2dec_digs_t;

  // Classified item: sign, unsigned magnitude, format
  typedef struct packed {
    logic                  neg;
    logic                  mode;
    logic [VALUE_BITS-1:0] mag;
  } s2dec_item_t;

  // Converted item: BCD digits, least significant digit at index 0
  typedef struct packed {
    logic        neg;
    logic        mode;
    s2dec_digs_t digs;
  } s2dec_conv_t;

endpackage

`default_nettype wire

FILE: rtl/s2dec_ifs.sv
// Channel interfaces: value input, character output and mode register write.
`default_nettype none

interface s2dec_in_if;
  import s2dec_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface s2dec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

interface s2dec_cfg_if;
  logic valid;
  logic ready;
  logic two_decimal_mode;
  modport source (output valid, output two_decimal_mode, input ready);
  modport sink   (input valid, input two_decimal_mode, output ready);
endinterface

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text converter.
// Usage:
//   in_ch  : one signed VALUE_BITS-bit value per transfer (valid/ready).
//   out_ch : one ASCII character per transfer, most significant first;
//            last_char marks the final character of each number. No terminator.
//   cfg_ch : writes two_decimal_mode (0 plain integer, 1 hundredths with
//            two decimals). Write it only while no item is in flight.
// Timing:
//   A 2-entry queue sits behind the input, so up to two values are taken
//   while earlier ones are still converting or being sent.
//   BCD conversion loads the magnitude into the shift-and-add-3 unit, runs
//   its steps and hands the result off; it takes a new value only once
//   the last is handed off. Emission is one character per clock while
//   out_ch.ready is high, with a gap between numbers; the next value
//   converts while the current one is being sent.
// Reset: rst_n low clears the mode to plain integer and empties the queue,
//   converter and output register.
// Stall: when out_ch.ready is low the output register holds its character;
//   the converter then holds its result and the queue fills, after which
//   in_ch.ready drops.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic  clk,
  input  wire logic  rst_n,
  s2dec_in_if.sink   in_ch,
  s2dec_out_if.source out_ch,
  s2dec_cfg_if.sink  cfg_ch
);
  import s2dec_pkg::*;

  logic        push_valid;
  logic        push_ready;
  s2dec_item_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  s2dec_item_t pop_item;
  logic        res_valid;
  logic        res_ready;
  s2dec_conv_t res_item;

  s2dec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  s2dec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  s2dec_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (pop_valid),
    .src_item  (pop_item),
    .src_ready (pop_ready),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready)
  );

  s2dec_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/s2dec_front.sv
// Front end: mode register, input acceptance and sign/magnitude split.
`default_nettype none

module s2dec_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  s2dec_in_if.sink             in_ch,
  s2dec_cfg_if.sink            cfg_ch,
  output logic                 push_valid,
  output s2dec_pkg::s2dec_item_t push_item,
  input  wire logic            push_ready
);
  import s2dec_pkg::*;

  logic                  mode_r;
  logic [VALUE_BITS-1:0] raw;
  logic                  neg;

  // Mode register, always writable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.two_decimal_mode;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Classify: sign bit and unsigned magnitude (most negative value maps exactly)
  assign raw = in_ch.value;
  assign neg = raw[VALUE_BITS-1];

  always_comb begin
    push_item.neg  = neg;
    push_item.mode = mode_r;
    push_item.mag  = neg ? VALUE_BITS'(~raw + VALUE_BITS'(1)) : raw;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

FILE: rtl/s2dec_queue.sv
// Small FIFO decoupling the front end from the converter.
`default_nettype none

module s2dec_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  input  s2dec_pkg::s2dec_item_t push_item,
  output logic                   push_ready,
  output logic                   pop_valid,
  output s2dec_pkg::s2dec_item_t pop_item,
  input  wire logic              pop_ready
);
  import s2dec_pkg::*;

  s2dec_item_t            mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r;
  logic                   push;
  logic                   pop;

  assign push_ready = (cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/s2dec_bcd.sv
// Binary to BCD converter: shift-and-add-3, several bits per clock.
`default_nettype none

module s2dec_bcd (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              src_valid,
  input  s2dec_pkg::s2dec_item_t src_item,
  output logic                   src_ready,
  output logic                   res_valid,
  output s2dec_pkg::s2dec_conv_t res_item,
  input  wire logic              res_ready
);
  import s2dec_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                  state_r;
  logic [STEP_W-1:0]       step_r;
  logic [SHIFT_BITS-1:0]   sh_r;
  logic [SHIFT_BITS-1:0]   sh_nxt;
  logic [MAG_DIGITS*4-1:0] bcd_r;
  logic [MAG_DIGITS*4-1:0] bcd_nxt;
  logic                    neg_r;
  logic                    mode_r;

  // One clock of double-dabble: BITS_PER_STEP adjust-and-shift rounds
  always_comb begin
    bcd_nxt = bcd_r;
    sh_nxt  = sh_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < MAG_DIGITS; d++) begin
        if (bcd_nxt[d*4 +: 4] >= 4'd5) begin
          bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[MAG_DIGITS*4-2:0], sh_nxt[SHIFT_BITS-1]};
      sh_nxt  = {sh_nxt[SHIFT_BITS-2:0], 1'b0};
    end
  end

  assign src_ready     = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res_item.neg  = neg_r;
  assign res_item.mode = mode_r;
  assign res_item.digs = bcd_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (src_valid) begin
            sh_r    <= SHIFT_BITS'(src_item.mag);
            bcd_r   <= '0;
            neg_r   <= src_item.neg;
            mode_r  <= src_item.mode;
            step_r  <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          sh_r   <= sh_nxt;
          bcd_r  <= bcd_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CONV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/s2dec_emit.sv
// Character sequencer: sign, digits and decimal point into the output register.
`default_nettype none

module s2dec_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  s2dec_pkg::s2dec_conv_t res_item,
  output logic                   res_ready,
  s2dec_out_if.source            out_ch
);
  import s2dec_pkg::*;

  s2dec_digs_t          digs_r;
  logic [DIG_IDX_W-1:0] idx_r;
  logic [DIG_IDX_W-1:0] hi;
  logic [DIG_IDX_W-1:0] start_idx;
  logic                 busy_r;
  logic                 neg_pend_r;
  logic                 dot_done_r;
  logic                 mode_r;
  logic                 out_v_r;
  logic [7:0]           out_char_r;
  logic                 out_last_r;
  logic                 ld;
  logic                 adv;
  logic                 is_sign;
  logic                 is_dot;
  logic [7:0]           ch_nxt;
  logic                 last_nxt;

  // Highest nonzero digit, padded to three digits in decimal mode
  always_comb begin
    hi = '0;
    for (int d = 0; d < MAG_DIGITS; d++) begin
      if (res_item.digs[d] != 4'd0) begin
        hi = DIG_IDX_W'(d);
      end
    end
    start_idx = (res_item.mode && (hi < DIG_IDX_W'(MIN_DIGITS - 1)))
              ? DIG_IDX_W'(MIN_DIGITS - 1) : hi;
  end

  assign res_ready = !busy_r;
  assign ld        = res_valid && !busy_r;
  assign adv       = busy_r && (!out_v_r || out_ch.ready);

  // Next character
  always_comb begin
    is_sign  = neg_pend_r;
    is_dot   = !neg_pend_r && mode_r && !dot_done_r && (idx_r == DIG_IDX_W'(1));
    if (is_sign) begin
      ch_nxt = CH_MINUS;
    end else if (is_dot) begin
      ch_nxt = CH_DOT;
    end else begin
      ch_nxt = CH_ZERO + {4'b0000, digs_r[idx_r]};
    end
    last_nxt = !is_sign && !is_dot && (idx_r == '0);
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (ld) begin
        digs_r     <= res_item.digs;
        neg_pend_r <= res_item.neg;
        mode_r     <= res_item.mode;
        dot_done_r <= 1'b0;
        idx_r      <= start_idx;
        busy_r     <= 1'b1;
      end else if (adv) begin
        out_char_r <= ch_nxt;
        out_last_r <= last_nxt;
        if (is_sign) begin
          neg_pend_r <= 1'b0;
        end else if (is_dot) begin
          dot_done_r <= 1'b1;
        end else if (idx_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.last_char = out_last_r;

`ifndef SYNTHESIS
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_char_r == CH_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last character");

  a_dot_only_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_char_r == CH_DOT) |-> (mode_r && !out_last_r))
    else $error("decimal point outside decimal mode or at end");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_char_r != CH_MINUS && out_char_r != CH_DOT)
      |-> (out_char_r >= CH_ZERO && out_char_r <= CH_NINE))
    else $error("BCD digit out of range");
`endif

endmodule

`default_nettype wire
